// ===== rtl/ikr_pkg.sv =====
// shared types, constants and a helper function for the integer k-th root block
`default_nettype none

package ikr_pkg;

  // field widths of the stream items
  localparam int unsigned RAD_BITS    = 64;
  localparam int unsigned EXP_BITS    = 7;
  localparam int unsigned S_TDATA_W   = 72;
  localparam int unsigned M_TDATA_W   = 64;

  // width of the exponent bit index (exponents below 64 have 6 bits)
  localparam int unsigned JW          = 3;

  // degree from which the root is one for any radicand above zero
  localparam logic [EXP_BITS-1:0] K_LIMIT = 7'd64;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_INIT,
    ST_LO,
    ST_HI,
    ST_EVAL,
    ST_NEXT,
    ST_OUT
  } ikr_state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic set_a;
    logic set_one;
    logic init;
    logic mul_lo;
    logic mul_hi;
    logic op_sq;
    logic acc_wr;
    logic j_dec;
    logic keep;
    logic b_dec;
    logic res_n;
  } ikr_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic easy_a;
    logic easy_one;
    logic fail;
    logic k_bit;
    logic j_zero;
    logic b_zero;
  } ikr_stat_t;

  // position of the highest set bit among the low six bits of the exponent
  function automatic logic [JW-1:0] msb_pos(input logic [EXP_BITS-1:0] k);
    logic [JW-1:0] pos;
    pos = '0;
    for (int i = 0; i < EXP_BITS - 1; i++) begin
      if (k[i]) begin
        pos = JW'(i);
      end
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ikr_dp.sv =====
// datapath: operand registers, shared half-width multiplier, power check and result
`default_nettype none

module ikr_dp import ikr_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  wire logic                clk_i,
  input  wire logic [RAD_BITS-1:0] radicand_i,
  input  wire logic [EXP_BITS-1:0] exponent_i,
  input  wire ikr_cmd_t            cmd_i,
  output ikr_stat_t                stat_o,
  output logic [RAD_BITS-1:0]      root_value_o
);

  localparam int unsigned HalfW = (VALUE_WIDTH + 1) / 2;
  localparam int unsigned AccW  = 2 * HalfW;
  localparam int unsigned ProdW = 3 * HalfW;
  localparam int unsigned BitW  = $clog2(HalfW);

  logic [VALUE_WIDTH-1:0] a_q;
  logic [EXP_BITS-1:0]    k_q;
  logic [HalfW-1:0]       n_q;
  logic [BitW-1:0]        b_q;
  logic [JW-1:0]          j_q;
  logic [AccW-1:0]        acc_q;
  logic [AccW-1:0]        mul_q;
  logic [AccW-1:0]        plo_q;
  logic [VALUE_WIDTH-1:0] res_q;

  logic [HalfW-1:0]       cand;
  logic [HalfW-1:0]       x_op;
  logic [HalfW-1:0]       y_op;
  logic [AccW-1:0]        mul_d;
  logic [ProdW-1:0]       prod;
  logic [ProdW-1:0]       a_ext;
  logic                   acc_hi_nz;
  logic                   fail;

  // trial root: kept bits plus the bit under test
  assign cand = n_q | (HalfW'(1) << b_q);

  // shared multiplier: one half of the accumulator times the other factor
  assign x_op  = cmd_i.mul_hi ? acc_q[AccW-1:HalfW] : acc_q[HalfW-1:0];
  assign y_op  = cmd_i.op_sq ? acc_q[HalfW-1:0] : cand;
  assign mul_d = x_op * y_op;

  // rebuild the full product from the two partial products and compare
  assign prod      = {mul_q, {HalfW{1'b0}}} + ProdW'(plo_q);
  assign a_ext     = ProdW'(a_q);
  assign acc_hi_nz = |acc_q[AccW-1:HalfW];
  assign fail      = (prod > a_ext) || (cmd_i.op_sq && acc_hi_nz);

  // operand and search registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q <= radicand_i[VALUE_WIDTH-1:0];
      k_q <= exponent_i;
      n_q <= '0;
      b_q <= BitW'(HalfW - 1);
    end else begin
      if (cmd_i.keep) begin
        n_q <= cand;
      end
      if (cmd_i.b_dec) begin
        b_q <= b_q - BitW'(1);
      end
    end
  end

  // accumulator and exponent bit index
  always_ff @(posedge clk_i) begin
    priority if (cmd_i.init) begin
      acc_q <= AccW'(cand);
      j_q   <= msb_pos(k_q) - JW'(1);
    end else begin
      if (cmd_i.acc_wr) begin
        acc_q <= prod[AccW-1:0];
      end
      if (cmd_i.j_dec) begin
        j_q <= j_q - JW'(1);
      end
    end
  end

  // partial product registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_lo || cmd_i.mul_hi) begin
      mul_q <= mul_d;
    end
    if (cmd_i.mul_hi) begin
      plo_q <= mul_q;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    priority if (cmd_i.set_a) begin
      res_q <= a_q;
    end else if (cmd_i.set_one) begin
      res_q <= VALUE_WIDTH'(1);
    end else if (cmd_i.res_n) begin
      res_q <= VALUE_WIDTH'(n_q);
    end
  end

  // status toward the controller
  always_comb begin
    stat_o.easy_a   = (a_q <= VALUE_WIDTH'(1)) || (k_q <= EXP_BITS'(1));
    stat_o.easy_one = (k_q >= K_LIMIT);
    stat_o.fail     = fail;
    stat_o.k_bit    = k_q[j_q];
    stat_o.j_zero   = (j_q == '0);
    stat_o.b_zero   = (b_q == '0);
  end

  assign root_value_o = RAD_BITS'(res_q);

endmodule

`default_nettype wire

// ===== rtl/ikr_ctrl.sv =====
// controller: sequences the bitwise root search and the square-and-multiply powering
`default_nettype none

module ikr_ctrl import ikr_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  input  wire ikr_stat_t stat_i,
  output ikr_cmd_t       cmd_o
);

  ikr_state_e state_q, state_d;
  logic       op_sq_q, op_sq_d;
  logic       step_more;

  // after a square, a set exponent bit calls for a multiply by the trial root
  assign step_more = op_sq_q && stat_i.k_bit;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_sq_q <= 1'b1;
    end else begin
      state_q <= state_d;
      op_sq_q <= op_sq_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    op_sq_d = op_sq_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat_i.easy_a || stat_i.easy_one) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        state_d = ST_LO;
        op_sq_d = 1'b1;
      end
      ST_LO:   state_d = ST_HI;
      ST_HI:   state_d = ST_EVAL;
      ST_EVAL: begin
        priority if (stat_i.fail) begin
          state_d = ST_NEXT;
        end else if (step_more) begin
          state_d = ST_LO;
          op_sq_d = 1'b0;
        end else if (stat_i.j_zero) begin
          state_d = ST_NEXT;
        end else begin
          state_d = ST_LO;
          op_sq_d = 1'b1;
        end
      end
      ST_NEXT: begin
        if (stat_i.b_zero) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_INIT;
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath commands
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    cmd_o.op_sq = op_sq_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_CHECK: begin
        priority if (stat_i.easy_a) begin
          cmd_o.set_a = 1'b1;
        end else if (stat_i.easy_one) begin
          cmd_o.set_one = 1'b1;
        end
      end
      ST_INIT: cmd_o.init   = 1'b1;
      ST_LO:   cmd_o.mul_lo = 1'b1;
      ST_HI:   cmd_o.mul_hi = 1'b1;
      ST_EVAL: begin
        if (!stat_i.fail) begin
          cmd_o.acc_wr = 1'b1;
          if (!step_more) begin
            if (stat_i.j_zero) begin
              cmd_o.keep = 1'b1;
            end else begin
              cmd_o.j_dec = 1'b1;
            end
          end
        end
      end
      ST_NEXT: begin
        if (stat_i.b_zero) begin
          cmd_o.res_n = 1'b1;
        end else begin
          cmd_o.b_dec = 1'b1;
        end
      end
      ST_OUT: out_valid_o = 1'b1;
      default: cmd_o.op_sq = op_sq_q;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/integer_kth_root.sv =====
// top level of the integer k-th root block: controller plus datapath
//
//  channel  | dir | tdata fields (low bit up)              | tuser / tlast
//  s_axis   | in  | radicand[63:0], exponent[70:64], pad[71] | none
//  m_axis   | out | root_value[63:0]                         | none
//
// One item at a time. Radicand 0 or 1, degree 0 or 1, or degree 64 and up: answered from ST_CHECK.
// Otherwise each of the (VALUE_WIDTH+1)/2 root bits passes ST_INIT and ST_NEXT, and each square
// and each multiply runs ST_LO, ST_HI and ST_EVAL on the single shared half-width multiplier;
// a rejected trial bit stops early.
// Reset clears only the controller; a stalled result holds and no new item is taken.
`default_nettype none

module integer_kth_root import ikr_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata_i,  // radicand[63:0], exponent[70:64]
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  output logic [M_TDATA_W-1:0]      m_axis_tdata_o   // root_value[63:0]
);

  ikr_cmd_t  cmd;
  ikr_stat_t stat;

  // controller
  ikr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath
  ikr_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .radicand_i   (s_axis_tdata_i[RAD_BITS-1:0]),
    .exponent_i   (s_axis_tdata_i[RAD_BITS+EXP_BITS-1:RAD_BITS]),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .root_value_o (m_axis_tdata_o)
  );

  // never take an item while a result is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input ready while result pending");

  // an accepted item closes the input side on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input still ready after item accepted");

  // a delivered result reopens the input side
  a_ready_after_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i) |=> (s_axis_tready_o && !m_axis_tvalid_o))
    else $error("block not idle after result delivered");

endmodule

`default_nettype wire

// ===== dv/integer_kth_root_checker.sv =====
// checker for the integer k-th root block: predicts each root and compares it with the output
module integer_kth_root_checker import ikr_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  input  logic                 s_axis_tready_i,
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,  // radicand[63:0], exponent[70:64]
  input  logic                 m_axis_tvalid_i,
  input  logic                 m_axis_tready_i,
  input  logic [M_TDATA_W-1:0] m_axis_tdata_i,  // root_value[63:0]
  output int unsigned          fail_count_o,
  output int unsigned          pending_roots_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] VALUE_MASK = {64{1'b1}} >> (64 - VALUE_WIDTH);

  // roots still owed by the block, oldest first
  logic [63:0] root_queue[$];

  initial begin
    fail_count_o    = 0;
    pending_roots_o = 0;
  end

  // largest n with n**k <= a for k above zero, built bit by bit from bit 31 down
  function automatic logic [63:0] kth_root_of(input logic [63:0] radicand,
                                              input logic [EXP_BITS-1:0] k);
    logic [63:0] a;
    logic [63:0] root;
    logic [63:0] trial;
    logic [63:0] acc;
    bit          fits;
    a = radicand & VALUE_MASK;
    if (a <= 64'd1 || k <= 1) begin
      return a;
    end
    if (k >= K_LIMIT) begin
      return 64'd1;
    end
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      acc   = 64'd1;
      fits  = 1'b1;
      // dividing first keeps every product inside 64 bits
      for (int i = 0; i < int'(k) && fits; i++) begin
        if (acc > a / trial) begin
          fits = 1'b0;
        end else begin
          acc = acc * trial;
        end
      end
      if (fits) begin
        root = trial;
      end
    end
    return root & VALUE_MASK;
  endfunction

  // record accepted items, check accepted roots
  always @(posedge clk_i) begin : watch_channels
    logic [63:0] want;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        root_queue.push_back(kth_root_of(s_axis_tdata_i[RAD_BITS-1:0],
                                         s_axis_tdata_i[RAD_BITS +: EXP_BITS]));
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (root_queue.size() == 0) begin
          $display("%0t: root_value with no item waiting: expected none, actual %h",
                   $time, m_axis_tdata_i[63:0]);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = root_queue.pop_front();
          if (m_axis_tdata_i[63:0] !== want) begin
            $display("%0t: root_value mismatch: expected %h, actual %h",
                     $time, want, m_axis_tdata_i[63:0]);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      pending_roots_o <= root_queue.size();
    end
  end

endmodule

// ===== dv/integer_kth_root_tb.sv =====
// testbench top for the integer k-th root block: clock, reset, stimulus and verdict
module integer_kth_root_tb;
  import ikr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VALUE_WIDTH  = 64;
  localparam int unsigned RANDOM_ITEMS = 550;
  localparam int unsigned HOLD_CYCLES  = 1500;
  localparam int unsigned STALL_LIMIT  = 12000;
  localparam int unsigned DRAIN_CYCLES = 1200;
  localparam logic [63:0] ALL_ONES     = {64{1'b1}};

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [S_TDATA_W-1:0] s_axis_tdata_i  = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata_o;

  int unsigned fail_count;
  int unsigned pending_roots;
  int unsigned stall_cycles = 0;
  int unsigned hold_left    = 0;
  logic        quiet        = 1'b0;
  logic        hold_req     = 1'b0;
  logic        hold_done    = 1'b0;

  always #5 clk_i = ~clk_i;

  integer_kth_root #(.VALUE_WIDTH(VALUE_WIDTH)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  integer_kth_root_checker #(.VALUE_WIDTH(VALUE_WIDTH)) checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .fail_count_o    (fail_count),
    .pending_roots_o (pending_roots)
  );

  // result side: random back-pressure, one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready_i <= 1'b0;
      hold_left       <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      m_axis_tready_i <= 1'b0;
      hold_left       <= HOLD_CYCLES;
      hold_done       <= 1'b1;
    end else begin
      m_axis_tready_i <= quiet || ($urandom_range(99) >= 22);
    end
  end

  // watchdog: too long without any item moving
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // base**k, bit 64 set when it does not fit in 64 bits
  function automatic logic [64:0] raise_to(input logic [63:0] base, input int unsigned k);
    logic [127:0] acc;
    acc = 128'd1;
    for (int unsigned i = 0; i < k; i++) begin
      acc = acc * base;
      if (acc[127:64] != 0) begin
        return {1'b1, 64'd0};
      end
    end
    return {1'b0, acc[63:0]};
  endfunction

  // offer one item, after an optional gap, and wait until it is taken
  task automatic push_item(input logic [63:0] radicand, input logic [EXP_BITS-1:0] k);
    int unsigned gap;
    gap = 0;
    if (!quiet && $urandom_range(99) < 22) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(1200, 50) : $urandom_range(6, 1);
    end
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {1'b0, k, radicand};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  initial begin
    logic [63:0]         radicand;
    logic [EXP_BITS-1:0] k;
    logic [63:0]         base;
    logic [64:0]         power;
    int unsigned         pick;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero and one, degrees zero and one, degree limit
    push_item(64'd0, 7'd2);
    push_item(64'd1, 7'd5);
    push_item(64'd0, 7'd0);
    push_item(64'd1, 7'd0);
    push_item(64'd1, 7'd127);
    push_item(ALL_ONES, 7'd0);
    push_item(ALL_ONES, 7'd1);
    push_item(ALL_ONES, 7'd64);
    push_item(ALL_ONES, 7'd127);
    push_item(64'd2, 7'd64);
    push_item(64'd2, 7'd127);
    // largest radicand at ordinary degrees
    push_item(ALL_ONES, 7'd2);
    push_item(ALL_ONES, 7'd3);
    push_item(ALL_ONES, 7'd32);
    push_item(ALL_ONES, 7'd63);
    // exact powers and their neighbors
    push_item(64'd2, 7'd63);
    push_item(64'd3, 7'd2);
    push_item(64'd4, 7'd2);
    push_item(64'hFFFF_FFFE_0000_0001, 7'd2);
    push_item(64'hFFFF_FFFE_0000_0000, 7'd2);
    push_item(64'h8000_0000_0000_0000, 7'd63);
    push_item(64'h7FFF_FFFF_FFFF_FFFF, 7'd63);
    push_item(64'h4000_0000_0000_0000, 7'd31);
    push_item(64'd27, 7'd3);
    push_item(64'd26, 7'd3);

    // random items
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 150) quiet <= 1'b1;
      if (n == 280) quiet <= 1'b0;
      if (n == 350) hold_req <= 1'b1;

      pick = $urandom_range(99);
      if (pick < 40) begin
        k = EXP_BITS'($urandom_range(8, 2));
      end else if (pick < 65) begin
        k = EXP_BITS'($urandom_range(63, 9));
      end else if (pick < 75) begin
        k = EXP_BITS'($urandom_range(127, 64));
      end else if (pick < 80) begin
        k = EXP_BITS'($urandom_range(1, 0));
      end else begin
        k = EXP_BITS'($urandom_range(127, 0));
      end

      pick = $urandom_range(99);
      if (k >= 2 && k < K_LIMIT && pick < 35) begin
        // around an exact power
        base = 64'($urandom) >> $urandom_range(31, 0);
        if (base == 0) base = 64'd1;
        power = raise_to(base, k);
        while (power[64]) begin
          base  = base >> 1;
          power = raise_to(base, k);
        end
        radicand = power[63:0] + 64'($urandom_range(2, 0)) - 64'd1;
      end else if (pick < 45) begin
        radicand = 64'($urandom_range(3, 0));
      end else if (pick < 75) begin
        radicand = {$urandom, $urandom};
      end else begin
        radicand = {$urandom, $urandom} >> $urandom_range(63, 0);
      end

      push_item(radicand, k);
    end
    s_axis_tvalid_i <= 1'b0;

    // drain: let the checker count the last item before waiting on it
    @(posedge clk_i);
    while (pending_roots != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ikr_pkg.sv
rtl/ikr_dp.sv
rtl/ikr_ctrl.sv
rtl/integer_kth_root.sv
dv/integer_kth_root_checker.sv
dv/integer_kth_root_tb.sv
